// File: sv/mbu_pkg.sv
`default_nettype none

package mbu_pkg;

    localparam int MAX_WORDS   = 64;
    localparam int ADDR_W      = $clog2(MAX_WORDS);
    localparam int HELD_W      = $clog2(MAX_WORDS + 1);
    localparam int FLAGS_W     = 63;
    localparam int CNT_W       = 6;
    localparam int TUPLE_W     = 24;
    localparam int WORD_W      = 64;
    localparam int GROUPS_W    = 13;
    localparam int GNUM_W      = 12;
    localparam int FOOT_W      = 16;
    localparam int STATUS_W    = 2;

    localparam logic [GROUPS_W-1:0] GROUPS_RESET = GROUPS_W'(256);
    localparam logic [GROUPS_W-1:0] GROUPS_MAX   = {GROUPS_W{1'b1}};
    localparam logic [CNT_W-1:0]    FLAGS_MAX    = CNT_W'(FLAGS_W);

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SHORT    = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

endpackage

`default_nettype wire

// File: sv/mbu_if.sv
`default_nettype none

interface mbu_word_if;
    logic                             valid;
    logic                             ready;
    logic [mbu_pkg::WORD_W-1:0]       result_word;
    logic                             buffer_start;

    modport source (output valid, output result_word, output buffer_start, input ready);
    modport sink (input valid, input result_word, input buffer_start, output ready);
endinterface

interface mbu_result_if;
    logic                             valid;
    logic                             ready;
    logic [mbu_pkg::TUPLE_W-1:0]      tuple_base;
    logic [mbu_pkg::FLAGS_W-1:0]      match_flags;
    logic [mbu_pkg::CNT_W-1:0]        flag_count;
    logic [mbu_pkg::CNT_W-1:0]        word_matches;
    logic [mbu_pkg::GNUM_W-1:0]       group_number;
    logic [mbu_pkg::FOOT_W-1:0]       group_tuples;
    logic [mbu_pkg::FOOT_W-1:0]       reported_matches;
    logic [mbu_pkg::STATUS_W-1:0]     group_status;
    logic                             group_last;

    modport source (
        output valid, output tuple_base, output match_flags, output flag_count,
        output word_matches, output group_number, output group_tuples,
        output reported_matches, output group_status, output group_last,
        input ready
    );
    modport sink (
        input valid, input tuple_base, input match_flags, input flag_count,
        input word_matches, input group_number, input group_tuples,
        input reported_matches, input group_status, input group_last,
        output ready
    );
endinterface

interface mbu_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mbu_pkg::GROUPS_W-1:0]     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/mbu_flag_extract.sv
`default_nettype none

module mbu_flag_extract (
    input  wire logic [mbu_pkg::FLAGS_W-1:0] word,
    input  wire logic [mbu_pkg::CNT_W-1:0]   count,
    output logic      [mbu_pkg::FLAGS_W-1:0] flags,
    output logic      [mbu_pkg::CNT_W-1:0]   set_count
);

    logic [mbu_pkg::FLAGS_W-1:0] rev;
    logic [mbu_pkg::CNT_W-1:0]   shift;

    // reverse so the top valid bit lands in bit 0 after the shift
    always_comb
    begin
        for (int k = 0; k < mbu_pkg::FLAGS_W; k++)
        begin
            rev[k] = word[mbu_pkg::FLAGS_W-1-k];
        end
    end

    assign shift = mbu_pkg::FLAGS_MAX - count;
    assign flags = rev >> shift;

    always_comb
    begin
        set_count = '0;
        for (int k = 0; k < mbu_pkg::FLAGS_W; k++)
        begin
            set_count = set_count + mbu_pkg::CNT_W'(flags[k]);
        end
    end

endmodule

`default_nettype wire

// File: sv/match_bitmap_unpacker.sv
// order: a data word is stored in the cycle it is accepted; after a footer is accepted, S_READ loads
// the stored word into rd_data_reg and S_EMIT registers its first result once the output is free
// throughput: one data word per cycle while idle, none while a group replays; each replayed word
// takes a read of the single store port, then extract and register; an empty group gives one result
// reset: counters, flags and handshakes clear at once and groups_per_buffer returns to 256;
// the word store is not cleared and needs no clearing pass, so words are taken right after reset
`default_nettype none

module match_bitmap_unpacker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    mbu_word_if.sink         words,
    mbu_result_if.source     results,
    mbu_cfg_if.sink          cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT,
        S_EMPTY
    } state_t;

    state_t state_reg, state_next;

    logic [mbu_pkg::FLAGS_W-1:0]  store_mem [mbu_pkg::MAX_WORDS];
    logic [mbu_pkg::FLAGS_W-1:0]  rd_data_reg;
    logic                         wr_en;

    logic [mbu_pkg::HELD_W-1:0]   held_reg;
    logic [mbu_pkg::TUPLE_W-1:0]  next_tuple_reg;
    logic [mbu_pkg::GROUPS_W-1:0] groups_done_reg;
    logic                         overflow_reg;
    logic                         finished_reg;
    logic [mbu_pkg::GROUPS_W-1:0] groups_cfg_reg;

    logic [mbu_pkg::HELD_W-1:0]   rep_held_reg;
    logic [mbu_pkg::HELD_W-1:0]   rep_idx_reg;
    logic [mbu_pkg::FOOT_W-1:0]   rep_rem_reg;
    logic [mbu_pkg::TUPLE_W-1:0]  rep_tup_reg;
    logic [mbu_pkg::GNUM_W-1:0]   rep_group_reg;
    logic [mbu_pkg::FOOT_W-1:0]   rep_tuples_reg;
    logic [mbu_pkg::FOOT_W-1:0]   rep_matches_reg;
    logic [mbu_pkg::STATUS_W-1:0] rep_status_reg;

    logic                         out_valid_reg;
    logic [mbu_pkg::TUPLE_W-1:0]  out_tuple_reg;
    logic [mbu_pkg::FLAGS_W-1:0]  out_flags_reg;
    logic [mbu_pkg::CNT_W-1:0]    out_count_reg;
    logic [mbu_pkg::CNT_W-1:0]    out_matches_reg;
    logic [mbu_pkg::GNUM_W-1:0]   out_group_reg;
    logic [mbu_pkg::FOOT_W-1:0]   out_tuples_reg;
    logic [mbu_pkg::FOOT_W-1:0]   out_rep_reg;
    logic [mbu_pkg::STATUS_W-1:0] out_status_reg;
    logic                         out_last_reg;

    logic                         in_acc;
    logic                         out_free;
    logic                         footer;
    logic [mbu_pkg::HELD_W-1:0]   eff_held;
    logic [mbu_pkg::TUPLE_W-1:0]  eff_tuple;
    logic [mbu_pkg::GROUPS_W-1:0] eff_groups;
    logic                         eff_ovf;
    logic                         eff_fin;
    logic [mbu_pkg::FOOT_W-1:0]   foot_tuples;
    logic [mbu_pkg::FOOT_W-1:0]   foot_matches;
    logic [mbu_pkg::FOOT_W-1:0]   capacity;
    logic [mbu_pkg::STATUS_W-1:0] foot_status;
    logic [mbu_pkg::GROUPS_W-1:0] groups_inc;
    logic [mbu_pkg::CNT_W-1:0]    take;
    logic                         take_last;
    logic [mbu_pkg::FLAGS_W-1:0]  ext_flags;
    logic [mbu_pkg::CNT_W-1:0]    ext_matches;

    assign words.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign in_acc      = words.valid && words.ready;
    assign out_free    = !out_valid_reg || results.ready;

    // buffer start clears the counters before the word is handled
    assign eff_held   = words.buffer_start ? '0 : held_reg;
    assign eff_tuple  = words.buffer_start ? '0 : next_tuple_reg;
    assign eff_groups = words.buffer_start ? '0 : groups_done_reg;
    assign eff_ovf    = words.buffer_start ? 1'b0 : overflow_reg;
    assign eff_fin    = words.buffer_start ? 1'b0 : finished_reg;

    assign footer       = words.result_word[mbu_pkg::WORD_W-1];
    assign foot_tuples  = words.result_word[mbu_pkg::FOOT_W-1:0];
    assign foot_matches = words.result_word[2*mbu_pkg::FOOT_W-1:mbu_pkg::FOOT_W];
    // held words times 63
    assign capacity     = mbu_pkg::FOOT_W'({eff_held, {mbu_pkg::CNT_W{1'b0}}})
                        - mbu_pkg::FOOT_W'(eff_held);
    assign groups_inc   = (eff_groups < mbu_pkg::GROUPS_MAX) ? eff_groups + 1'b1 : eff_groups;

    always_comb
    begin
        if (eff_ovf)
        begin
            foot_status = mbu_pkg::STATUS_OVERFLOW;
        end
        else if (foot_tuples > capacity)
        begin
            foot_status = mbu_pkg::STATUS_SHORT;
        end
        else
        begin
            foot_status = mbu_pkg::STATUS_OK;
        end
    end

    assign wr_en = in_acc && !eff_fin && !footer
                && (eff_held < mbu_pkg::HELD_W'(mbu_pkg::MAX_WORDS));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[eff_held[mbu_pkg::ADDR_W-1:0]] <= words.result_word[mbu_pkg::FLAGS_W-1:0];
        end
        rd_data_reg <= store_mem[rep_idx_reg[mbu_pkg::ADDR_W-1:0]];
    end

    assign take = (rep_rem_reg > mbu_pkg::FOOT_W'(mbu_pkg::FLAGS_W))
                ? mbu_pkg::FLAGS_MAX : rep_rem_reg[mbu_pkg::CNT_W-1:0];
    assign take_last = (rep_idx_reg + 1'b1 == rep_held_reg)
                    || (rep_rem_reg <= mbu_pkg::FOOT_W'(mbu_pkg::FLAGS_W));

    mbu_flag_extract u_extract (
        .word      (rd_data_reg),
        .count     (take),
        .flags     (ext_flags),
        .set_count (ext_matches)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && !eff_fin && footer)
                begin
                    if (eff_held == '0 || foot_tuples == '0)
                    begin
                        state_next = S_EMPTY;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = take_last ? S_IDLE : S_READ;
                end
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            held_reg        <= '0;
            next_tuple_reg  <= '0;
            groups_done_reg <= '0;
            overflow_reg    <= 1'b0;
            finished_reg    <= 1'b0;
            groups_cfg_reg  <= mbu_pkg::GROUPS_RESET;
            out_valid_reg   <= 1'b0;
            rep_idx_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                groups_cfg_reg <= cfg.data;
            end
            if (out_valid_reg && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (in_acc)
            begin
                held_reg        <= eff_held;
                next_tuple_reg  <= eff_tuple;
                groups_done_reg <= eff_groups;
                overflow_reg    <= eff_ovf;
                finished_reg    <= eff_fin;
                if (!eff_fin)
                begin
                    if (!footer)
                    begin
                        if (wr_en)
                        begin
                            held_reg <= eff_held + 1'b1;
                        end
                        else
                        begin
                            overflow_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        rep_held_reg    <= eff_held;
                        rep_idx_reg     <= '0;
                        rep_rem_reg     <= foot_tuples;
                        rep_tup_reg     <= eff_tuple;
                        rep_group_reg   <= eff_groups[mbu_pkg::GNUM_W-1:0];
                        rep_tuples_reg  <= foot_tuples;
                        rep_matches_reg <= foot_matches;
                        rep_status_reg  <= foot_status;
                        next_tuple_reg  <= eff_tuple + mbu_pkg::TUPLE_W'(foot_tuples);
                        held_reg        <= '0;
                        overflow_reg    <= 1'b0;
                        groups_done_reg <= groups_inc;
                        finished_reg    <= (groups_inc >= groups_cfg_reg);
                    end
                end
            end

            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg   <= 1'b1;
                out_tuple_reg   <= rep_tup_reg;
                out_flags_reg   <= ext_flags;
                out_count_reg   <= take;
                out_matches_reg <= ext_matches;
                out_group_reg   <= rep_group_reg;
                out_tuples_reg  <= rep_tuples_reg;
                out_rep_reg     <= rep_matches_reg;
                out_status_reg  <= rep_status_reg;
                out_last_reg    <= take_last;
                rep_idx_reg     <= rep_idx_reg + 1'b1;
                rep_rem_reg     <= rep_rem_reg - mbu_pkg::FOOT_W'(take);
                rep_tup_reg     <= rep_tup_reg + mbu_pkg::TUPLE_W'(take);
            end

            if (state_reg == S_EMPTY && out_free)
            begin
                out_valid_reg   <= 1'b1;
                out_tuple_reg   <= rep_tup_reg;
                out_flags_reg   <= '0;
                out_count_reg   <= '0;
                out_matches_reg <= '0;
                out_group_reg   <= rep_group_reg;
                out_tuples_reg  <= rep_tuples_reg;
                out_rep_reg     <= rep_matches_reg;
                out_status_reg  <= rep_status_reg;
                out_last_reg    <= 1'b1;
            end
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.tuple_base       = out_tuple_reg;
    assign results.match_flags      = out_flags_reg;
    assign results.flag_count       = out_count_reg;
    assign results.word_matches     = out_matches_reg;
    assign results.group_number     = out_group_reg;
    assign results.group_tuples     = out_tuples_reg;
    assign results.reported_matches = out_rep_reg;
    assign results.group_status     = out_status_reg;
    assign results.group_last       = out_last_reg;

endmodule

`default_nettype wire

// File: bench/match_bitmap_unpacker_tb.sv
`timescale 1ns / 1ps

module match_bitmap_unpacker_tb;

    localparam int QUIET_LIMIT = 2000;
    localparam logic [mbu_pkg::WORD_W-1:0] FOOTER_BIT = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [mbu_pkg::TUPLE_W-1:0] tuple_base;
        logic [mbu_pkg::FLAGS_W-1:0] match_flags;
        logic [mbu_pkg::CNT_W-1:0]   flag_count;
        logic [mbu_pkg::CNT_W-1:0]   word_matches;
        logic [mbu_pkg::GNUM_W-1:0]  group_number;
        logic [mbu_pkg::FOOT_W-1:0]  group_tuples;
        logic [mbu_pkg::FOOT_W-1:0]  reported_matches;
        mbu_pkg::status_t            group_status;
        logic                        group_last;
    } flag_result_t;

    typedef enum int {
        DO_WORD,
        DO_CFG
    } step_kind_t;

    typedef struct {
        step_kind_t                  kind;
        logic [mbu_pkg::WORD_W-1:0]  word;
        bit                          start;
        int                          reps;
        bit                          typed;
        flag_result_t                want;
    } bench_step_t;

    logic clk = 1'b0;
    logic rst_n;

    mbu_word_if   word_ch();
    mbu_result_if res_ch();
    mbu_cfg_if    cfg_ch();

    match_bitmap_unpacker uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .words   (word_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    always #5 clk = ~clk;

    // unpacker state as the bench sees it
    logic [mbu_pkg::FLAGS_W-1:0]  held_words [mbu_pkg::MAX_WORDS];
    int unsigned                  held_cnt = 0;
    logic [mbu_pkg::TUPLE_W-1:0]  tuple_next = '0;
    logic [mbu_pkg::GROUPS_W-1:0] groups_seen = '0;
    logic [mbu_pkg::GROUPS_W-1:0] groups_cfg = mbu_pkg::GROUPS_RESET;
    bit                           overflowed = 1'b0;
    bit                           finished = 1'b0;

    flag_result_t owed [$];
    int  errors = 0;
    int  words_taken = 0;
    int  stall_left = 0;
    int  quiet = 0;
    bit  src_idle = 1'b1;
    bit  snk_idle = 1'b1;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 50);
    endfunction

    // returns 0 when the word is ignored because the buffer is finished
    function automatic bit unpack_word(input logic [mbu_pkg::WORD_W-1:0] w, input bit s,
                                       ref flag_result_t fresh [$]);
        int unsigned ntups, left, n, i, j;
        mbu_pkg::status_t st;
        flag_result_t r;
        logic [mbu_pkg::TUPLE_W-1:0] base;
        if (s)
        begin
            held_cnt = 0;
            tuple_next = '0;
            groups_seen = '0;
            overflowed = 1'b0;
            finished = 1'b0;
        end
        if (finished)
            return 1'b0;
        if (!w[mbu_pkg::WORD_W-1])
        begin
            if (held_cnt < mbu_pkg::MAX_WORDS)
            begin
                held_words[held_cnt] = w[mbu_pkg::FLAGS_W-1:0];
                held_cnt++;
            end
            else
                overflowed = 1'b1;
            return 1'b1;
        end
        ntups = w[15:0];
        left = ntups;
        for (i = 0; i < held_cnt; i++)
            left -= (left > mbu_pkg::FLAGS_W) ? mbu_pkg::FLAGS_W : left;
        st = overflowed ? mbu_pkg::STATUS_OVERFLOW
           : (left != 0 ? mbu_pkg::STATUS_SHORT : mbu_pkg::STATUS_OK);
        r = '0;
        r.group_number = groups_seen[mbu_pkg::GNUM_W-1:0];
        r.group_tuples = w[15:0];
        r.reported_matches = w[31:16];
        r.group_status = st;
        left = ntups;
        base = tuple_next;
        for (i = 0; i < held_cnt && left != 0; i++)
        begin
            n = (left > mbu_pkg::FLAGS_W) ? mbu_pkg::FLAGS_W : left;
            r.tuple_base = base;
            r.match_flags = '0;
            for (j = 0; j < n; j++)
                r.match_flags[j] = held_words[i][n-1-j];
            r.flag_count = mbu_pkg::CNT_W'(n);
            r.word_matches = mbu_pkg::CNT_W'($countones(r.match_flags));
            fresh = {fresh, r};
            base = base + mbu_pkg::TUPLE_W'(n);
            left -= n;
        end
        if (fresh.size() == 0)
        begin
            r.tuple_base = tuple_next;
            r.match_flags = '0;
            r.flag_count = '0;
            r.word_matches = '0;
            fresh = {fresh, r};
        end
        fresh[fresh.size()-1].group_last = 1'b1;
        tuple_next = tuple_next + mbu_pkg::TUPLE_W'(ntups);
        held_cnt = 0;
        overflowed = 1'b0;
        if (groups_seen != mbu_pkg::GROUPS_MAX)
            groups_seen++;
        if (groups_seen >= groups_cfg)
            finished = 1'b1;
        return 1'b1;
    endfunction

    task automatic send_word(input logic [mbu_pkg::WORD_W-1:0] w, input bit s, input bit typed,
                             input flag_result_t want);
        int gap;
        flag_result_t fresh [$];
        gap = src_idle ? idle_len() : 0;
        if (gap > 0)
        begin
            word_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_ch.valid <= 1'b1;
        word_ch.result_word <= w;
        word_ch.buffer_start <= s;
        @(posedge clk);
        while (!word_ch.ready)
            @(posedge clk);
        void'(unpack_word(w, s, fresh));
        words_taken++;
        if (typed)
            owed = {owed, want};
        else
            owed = {owed, fresh};
    endtask

    task automatic write_cfg(input logic [mbu_pkg::GROUPS_W-1:0] v);
        word_ch.valid <= 1'b0;
        while (owed.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        groups_cfg = v;
    endtask

    function automatic void check_field(input string name,
                                        input logic [mbu_pkg::WORD_W-1:0] want,
                                        input logic [mbu_pkg::WORD_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        flag_result_t got, want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = '{res_ch.tuple_base, res_ch.match_flags, res_ch.flag_count,
                    res_ch.word_matches, res_ch.group_number, res_ch.group_tuples,
                    res_ch.reported_matches, mbu_pkg::status_t'(res_ch.group_status),
                    res_ch.group_last};
            if (owed.size() == 0)
            begin
                errors++;
                $display("%0t unexpected word: expected none actual base %0h flags %0h",
                         $time, got.tuple_base, got.match_flags);
            end
            else
            begin
                want = owed.pop_front();
                check_field("tuple_base", want.tuple_base, got.tuple_base);
                check_field("match_flags", want.match_flags, got.match_flags);
                check_field("flag_count", want.flag_count, got.flag_count);
                check_field("word_matches", want.word_matches, got.word_matches);
                check_field("group_number", want.group_number, got.group_number);
                check_field("group_tuples", want.group_tuples, got.group_tuples);
                check_field("reported_matches", want.reported_matches, got.reported_matches);
                check_field("group_status", want.group_status, got.group_status);
                check_field("group_last", want.group_last, got.group_last);
            end
        end
    end

    // sink stalls
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            if (snk_idle && $urandom_range(0, 3) == 0)
                stall_left <= idle_len();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (word_ch.valid && word_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        bench_step_t plan [$];
        logic [mbu_pkg::WORD_W-1:0] r64;
        logic [mbu_pkg::GROUPS_W-1:0] cfg_val;
        int goal, phase, ngroups, g, nw, k, cap, ntups;
        bit fresh_buf, s;

        rst_n = 1'b0;
        word_ch.valid = 1'b0;
        word_ch.result_word = '0;
        word_ch.buffer_start = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;

        plan = '{
            '{DO_WORD, FOOTER_BIT, 1, 1, 1,
              '{24'd0, 63'd0, 6'd0, 6'd0, 12'd0, 16'd0, 16'd0, mbu_pkg::STATUS_OK, 1'b1}},
            '{DO_WORD, FOOTER_BIT | 64'h0003_0005, 0, 1, 1,
              '{24'd0, 63'd0, 6'd0, 6'd0, 12'd1, 16'd5, 16'd3, mbu_pkg::STATUS_SHORT, 1'b1}},
            '{DO_WORD, 64'h7FFF_FFFF_FFFF_FFFF, 0, 1, 0, '0},
            '{DO_WORD, 64'h0000_0000_0000_0000, 0, 1, 0, '0},
            '{DO_WORD, 64'h5555_5555_5555_5555, 0, 1, 0, '0},
            '{DO_WORD, 64'hFFFF_FFFF_FFFF_00BD, 0, 1, 0, '0},
            '{DO_WORD, 64'h2AAA_AAAA_AAAA_AAAA, 0, 1, 0, '0},
            '{DO_WORD, 64'h4000_0000_0000_0001, 0, 1, 0, '0},
            '{DO_WORD, FOOTER_BIT | 64'h0007_0046, 0, 1, 0, '0},
            '{DO_WORD, 64'h0123_4567_89AB_CDEF, 0, 1, 0, '0},
            '{DO_WORD, 64'h7EDC_BA98_7654_3210, 0, 1, 0, '0},
            // surplus word
            '{DO_WORD, FOOTER_BIT | 64'h0002_000A, 0, 1, 0, '0},
            '{DO_WORD, 64'h0000_0000_0000_0001, 0, 1, 0, '0},
            '{DO_WORD, FOOTER_BIT | 64'h0001_FFFF, 0, 1, 0, '0},
            // overflow and short together
            '{DO_WORD, 64'h3C3C_3C3C_3C3C_3C3C, 0, 65, 0, '0},
            '{DO_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1, 0, '0},
            // new buffer mid-group
            '{DO_WORD, 64'h0000_0000_0000_0007, 0, 1, 0, '0},
            '{DO_WORD, 64'h0000_0000_0000_07FF, 1, 1, 0, '0},
            '{DO_WORD, FOOTER_BIT | 64'h0000_0003, 0, 1, 1,
              '{24'd0, 63'h7, 6'd3, 6'd3, 12'd0, 16'd3, 16'd0, mbu_pkg::STATUS_OK, 1'b1}},
            // zero groups per buffer, then ignored words
            '{DO_CFG, 64'd0, 0, 1, 0, '0},
            '{DO_WORD, 64'h0000_0000_0000_0015, 1, 1, 0, '0},
            '{DO_WORD, FOOTER_BIT | 64'h0000_0005, 0, 1, 0, '0},
            '{DO_WORD, 64'h7FFF_FFFF_FFFF_FFFF, 0, 1, 0, '0},
            '{DO_WORD, FOOTER_BIT | 64'h0000_0005, 0, 1, 0, '0},
            '{DO_CFG, 64'd1, 0, 1, 0, '0},
            '{DO_WORD, FOOTER_BIT | 64'h0000_0002, 1, 1, 1,
              '{24'd0, 63'd0, 6'd0, 6'd0, 12'd0, 16'd2, 16'd0, mbu_pkg::STATUS_SHORT, 1'b1}},
            '{DO_WORD, FOOTER_BIT, 0, 1, 0, '0},
            // new buffer after a finished one
            '{DO_WORD, 64'h0000_0000_0000_0005, 1, 1, 0, '0},
            '{DO_WORD, FOOTER_BIT | 64'h0000_0002, 0, 1, 0, '0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[p])
        begin
            if (plan[p].kind == DO_CFG)
                write_cfg(plan[p].word[mbu_pkg::GROUPS_W-1:0]);
            else
                repeat (plan[p].reps)
                    send_word(plan[p].word, plan[p].start, plan[p].typed, plan[p].want);
        end

        goal = words_taken + 70;
        phase = 0;
        while (words_taken < goal)
        begin
            if (phase == 0)
                cfg_val = 13'd4096;
            else if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: cfg_val = 13'd0;
                    1: cfg_val = 13'd1;
                    2: cfg_val = 13'd4096;
                    default: cfg_val = 13'd8191;
                endcase
            end
            else
                cfg_val = mbu_pkg::GROUPS_W'($urandom_range(1, 8));
            write_cfg(cfg_val);
            src_idle = $urandom_range(0, 3) != 0;
            snk_idle = $urandom_range(0, 3) != 0;
            ngroups = $urandom_range(1, 8);
            fresh_buf = 1'b1;
            for (g = 0; g < ngroups && words_taken < goal; g++)
            begin
                k = $urandom_range(0, 9);
                if (k < 7)
                    nw = $urandom_range(0, 3);
                else if (k < 9)
                    nw = $urandom_range(4, 10);
                else
                    nw = $urandom_range(60, 66);
                for (k = 0; k < nw; k++)
                begin
                    r64 = {$urandom, $urandom};
                    s = fresh_buf || ($urandom_range(0, 39) == 0);
                    fresh_buf = 1'b0;
                    send_word({1'b0, r64[mbu_pkg::FLAGS_W-1:0]}, s, 1'b0, '0);
                end
                cap = ((nw > mbu_pkg::MAX_WORDS) ? mbu_pkg::MAX_WORDS : nw) * mbu_pkg::FLAGS_W;
                case ($urandom_range(0, 3))
                    0: ntups = cap;
                    1: ntups = (cap == 0) ? 0 : $urandom_range(0, cap - 1);
                    2: ntups = cap + $urandom_range(1, 100);
                    default: ntups = $urandom_range(0, 65535);
                endcase
                if (ntups > 65535)
                    ntups = 65535;
                r64 = {$urandom, $urandom};
                s = fresh_buf || ($urandom_range(0, 29) == 0);
                fresh_buf = 1'b0;
                send_word({1'b1, r64[62:32], r64[15:0], mbu_pkg::FOOT_W'(ntups)}, s, 1'b0, '0);
            end
            phase++;
        end

        word_ch.valid <= 1'b0;
        while (owed.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
